>>> hw/rtl/bra_pkg.sv
// shared constants and codes for the bone reference admission block
`default_nettype none

package bra_pkg;

    // default sizing
    localparam int BONES_DEF     = 128;
    localparam int WPV_DEF       = 4;
    localparam int TRI_VERTS     = 3;

    // fixed field widths
    localparam int FUNC_W        = 2;
    localparam int BONE_W        = 7;
    localparam int STATUS_W      = 2;
    localparam int NEW_W         = 4;
    localparam int TOTAL_W       = 8;

    // configuration port
    localparam int APB_DATA_W    = 32;
    localparam int APB_ADDR_W    = 3;
    localparam logic REG_MAX_REF = 1'b0;   // register select, paddr[2]
    localparam logic [TOTAL_W-1:0] MAX_REF_RESET = 8'd64;

    // request codes
    localparam logic [FUNC_W-1:0] FUNC_SLOT  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_END   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVER      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_WEIGHT = 2'd2;

endpackage

`default_nettype wire

>>> hw/rtl/bra_ram.sv
// generic single-clock ram, one write port, one registered read port
`default_nettype none

module bra_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/bone_reference_admission_unit.sv
// bone reference admission: per-triangle bone gathering against a capped reference set
// weight slot: busy for the flag ram lookup after acceptance; ignored or over-limit none
// end of triangle: result in the cycle after acceptance, or after the commit states when bones are committed
// clear request and reset: flag ram sweep over all BONES entries with busy high
// results are single-cycle strobes; the receiver cannot stall, config is always ready
// reset: synchronous active low, limit register returns to 64, triangle state dropped
`default_nettype none

module bone_reference_admission_unit #(
    parameter int BONES              = bra_pkg::BONES_DEF,
    parameter int WEIGHTS_PER_VERTEX = bra_pkg::WPV_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // request channel
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [bra_pkg::FUNC_W-1:0]       i_func,
    input  wire logic [bra_pkg::BONE_W-1:0]       i_bone_index,
    // result channel
    output logic                                  o_valid,
    output logic [bra_pkg::STATUS_W-1:0]          o_status,
    output logic [bra_pkg::NEW_W-1:0]             o_new_bones,
    output logic [bra_pkg::TOTAL_W-1:0]           o_total_referenced,
    // configuration port
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [bra_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [bra_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bra_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                  pready
);

    import bra_pkg::*;

    localparam int SLOTS = TRI_VERTS * WEIGHTS_PER_VERTEX;
    localparam int AW    = (BONES > 1) ? $clog2(BONES) : 1;
    localparam int CW    = ((AW > BONE_W) ? AW : BONE_W) + 1;
    localparam int PW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NW    = $clog2(SLOTS + 1);

    // state codes
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_CHECK  = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;
    localparam logic [1:0] S_CLEAR  = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [TOTAL_W-1:0]  r_max, n_max;
    logic [TOTAL_W-1:0]  r_total, n_total;
    logic [NW-1:0]       r_pcount, n_pcount;
    logic [NW-1:0]       r_slot, n_slot;
    logic                r_saw, n_saw;
    logic                r_over, n_over;
    logic [BONE_W-1:0]   r_bone, n_bone;
    logic [PW-1:0]       r_idx, n_idx;
    logic [AW-1:0]       r_clr, n_clr;
    logic [BONE_W-1:0]   r_pend [SLOTS];
    logic                w_pend_we;

    logic                r_valid, n_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [NEW_W-1:0]    r_new, n_new;
    logic [TOTAL_W-1:0]  r_out_total, n_out_total;

    logic                w_accept;
    logic                w_cfg_we;
    logic [CW-1:0]       w_bone_ext;
    logic                w_in_range;
    logic                w_ref_flag;
    logic                w_hit;
    logic                w_limit;
    logic [BONE_W-1:0]   w_commit_bone;
    logic [CW-1:0]       w_commit_ext;
    logic                w_ram_we;
    logic [AW-1:0]       w_ram_waddr;
    logic                w_ram_wdata;
    logic                w_last;

    assign w_accept = start && !busy;
    assign busy     = (r_state != S_IDLE);

    // configuration register
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && (paddr[2] == REG_MAX_REF);
    assign prdata   = (paddr[2] == REG_MAX_REF) ?
                      {{(APB_DATA_W-TOTAL_W){1'b0}}, r_max} : '0;

    // bone range and flag ram addressing
    assign w_bone_ext = CW'(i_bone_index);
    assign w_in_range = (w_bone_ext < CW'(BONES));

    assign w_commit_bone = r_pend[r_idx];
    assign w_commit_ext  = CW'(w_commit_bone);
    assign w_last        = ((NW'(r_idx) + NW'(1)) == r_pcount);

    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_waddr = r_clr;
        w_ram_wdata = 1'b0;
        case (r_state)
            S_CLEAR: begin
                w_ram_we = 1'b1;
            end
            S_COMMIT: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = w_commit_ext[AW-1:0];
                w_ram_wdata = 1'b1;
            end
            default: begin
                w_ram_we = 1'b0;
            end
        endcase
    end

    bra_ram #(
        .WIDTH (1),
        .DEPTH (BONES)
    ) u_flags (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_bone_ext[AW-1:0]),
        .o_rdata (w_ref_flag)
    );

    // parallel match against the pending bones
    always_comb begin
        w_hit = 1'b0;
        for (int k = 0; k < SLOTS; k++) begin
            if ((NW'(k) < r_pcount) && (r_pend[k] == r_bone)) begin
                w_hit = 1'b1;
            end
        end
    end

    // limit check on referenced plus pending
    assign w_limit = (({1'b0, r_total} + (TOTAL_W+1)'(r_pcount)) >= {1'b0, r_max});

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_max       = w_cfg_we ? pwdata[TOTAL_W-1:0] : r_max;
        n_total     = r_total;
        n_pcount    = r_pcount;
        n_slot      = r_slot;
        n_saw       = r_saw;
        n_over      = r_over;
        n_bone      = r_bone;
        n_idx       = r_idx;
        n_clr       = r_clr;
        n_valid     = 1'b0;
        n_status    = r_status;
        n_new       = r_new;
        n_out_total = r_out_total;
        w_pend_we   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_func)
                        FUNC_SLOT: begin
                            if (w_in_range && (r_slot < NW'(SLOTS))) begin
                                n_slot = r_slot + NW'(1);
                                n_saw  = 1'b1;
                                if (!r_over) begin
                                    n_bone  = i_bone_index;
                                    n_state = S_CHECK;
                                end
                            end
                        end
                        FUNC_END: begin
                            if (r_over || !r_saw || (r_pcount == '0)) begin
                                n_valid     = 1'b1;
                                n_status    = r_over ? ST_OVER :
                                              (!r_saw ? ST_NO_WEIGHT : ST_OK);
                                n_new       = '0;
                                n_out_total = r_total;
                                n_pcount    = '0;
                                n_slot      = '0;
                                n_saw       = 1'b0;
                                n_over      = 1'b0;
                            end else begin
                                n_idx   = '0;
                                n_state = S_COMMIT;
                            end
                        end
                        FUNC_CLEAR: begin
                            n_total  = '0;
                            n_pcount = '0;
                            n_slot   = '0;
                            n_saw    = 1'b0;
                            n_over   = 1'b0;
                            n_clr    = '0;
                            n_state  = S_CLEAR;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_CHECK: begin
                // flag from ram, then pending match, then limit
                n_state = S_IDLE;
                if (!w_ref_flag && !w_hit) begin
                    if (w_limit) begin
                        n_over = 1'b1;
                    end else if (r_pcount < NW'(SLOTS)) begin
                        w_pend_we = 1'b1;
                        n_pcount  = r_pcount + NW'(1);
                    end
                end
            end
            S_COMMIT: begin
                // mark one pending bone per cycle
                n_total = r_total + TOTAL_W'(1);
                n_idx   = r_idx + PW'(1);
                if (w_last) begin
                    n_valid     = 1'b1;
                    n_status    = ST_OK;
                    n_new       = NEW_W'(r_pcount);
                    n_out_total = r_total + TOTAL_W'(1);
                    n_pcount    = '0;
                    n_slot      = '0;
                    n_saw       = 1'b0;
                    n_over      = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            S_CLEAR: begin
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(BONES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_max    <= MAX_REF_RESET;
            r_total  <= '0;
            r_pcount <= '0;
            r_slot   <= '0;
            r_saw    <= 1'b0;
            r_over   <= 1'b0;
            r_idx    <= '0;
            r_clr    <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_max    <= n_max;
            r_total  <= n_total;
            r_pcount <= n_pcount;
            r_slot   <= n_slot;
            r_saw    <= n_saw;
            r_over   <= n_over;
            r_idx    <= n_idx;
            r_clr    <= n_clr;
            r_valid  <= n_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_bone      <= n_bone;
        r_status    <= n_status;
        r_new       <= n_new;
        r_out_total <= n_out_total;
        if (w_pend_we) begin
            r_pend[r_pcount[PW-1:0]] <= r_bone;
        end
    end

    assign o_valid            = r_valid;
    assign o_status           = r_status;
    assign o_new_bones        = r_new;
    assign o_total_referenced = r_out_total;

endmodule

`default_nettype wire

>>> test/testbench.sv
// self-checking testbench for the bone reference admission unit
`timescale 1ns / 1ps

module testbench;
    import bra_pkg::*;

    // request code the block leaves unused
    localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;
    localparam logic [APB_ADDR_W-1:0] LIMIT_ADDR = {REG_MAX_REF, 2'b00};
    localparam int SETTLE_CYCLES = BONES_DEF + 8;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 900;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [NEW_W-1:0]    new_bones;
        logic [TOTAL_W-1:0]  total;
    } t_verdict;

    // tracks the reference set and triangle in progress, queues due verdicts
    class admission_check;
        localparam int SLOT_CAP = TRI_VERTS * WPV_DEF;

        logic [TOTAL_W-1:0] limit;
        bit                 flags[BONES_DEF];
        logic [TOTAL_W-1:0] total;
        logic [BONE_W-1:0]  pending[$];
        int                 slots;
        bit                 saw_weight;
        bit                 over;
        t_verdict           verdicts_due[$];
        int                 faults;

        function new();
            limit = MAX_REF_RESET;
            foreach (flags[k]) flags[k] = 1'b0;
            total = '0;
            faults = 0;
            drop_triangle();
        endfunction

        function void drop_triangle();
            pending.delete();
            slots = 0;
            saw_weight = 1'b0;
            over = 1'b0;
        endfunction

        function void set_limit(logic [TOTAL_W-1:0] v);
            limit = v;
        endfunction

        function void note_mismatch(string what, int unsigned want, int unsigned got);
            faults++;
            if (faults <= 10)
                $display("mismatch on %s: expected %0d, got %0d", what, want, got);
        endfunction

        function void note_request(logic [FUNC_W-1:0] f, logic [BONE_W-1:0] bone);
            t_verdict v;
            bit dup;
            int added;
            case (f)
                FUNC_SLOT: begin
                    if (slots >= SLOT_CAP)
                        return;
                    slots++;
                    saw_weight = 1'b1;
                    if (over || flags[bone])
                        return;
                    dup = 1'b0;
                    foreach (pending[k])
                        if (pending[k] == bone) dup = 1'b1;
                    if (dup)
                        return;
                    // limit check only for a bone that is new to mesh and triangle
                    if (int'(total) + pending.size() >= int'(limit))
                        over = 1'b1;
                    else
                        pending.push_back(bone);
                end
                FUNC_END: begin
                    added = 0;
                    if (over) begin
                        v.status = ST_OVER;
                    end else if (!saw_weight) begin
                        v.status = ST_NO_WEIGHT;
                    end else begin
                        v.status = ST_OK;
                        foreach (pending[k]) begin
                            if (!flags[pending[k]]) begin
                                flags[pending[k]] = 1'b1;
                                total = total + 1'b1;
                                added++;
                            end
                        end
                    end
                    v.new_bones = added[NEW_W-1:0];
                    v.total = total;
                    verdicts_due.push_back(v);
                    drop_triangle();
                end
                FUNC_CLEAR: begin
                    foreach (flags[k]) flags[k] = 1'b0;
                    total = '0;
                    drop_triangle();
                end
                default: ;
            endcase
        endfunction

        function void check_verdict(t_verdict got);
            t_verdict want;
            if (verdicts_due.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("result with nothing expected: status %0d new %0d total %0d",
                             got.status, got.new_bones, got.total);
                return;
            end
            want = verdicts_due.pop_front();
            if (got.status !== want.status)
                note_mismatch("status", want.status, got.status);
            if (got.new_bones !== want.new_bones)
                note_mismatch("new_bones", want.new_bones, got.new_bones);
            if (got.total !== want.total)
                note_mismatch("total_referenced", want.total, got.total);
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [FUNC_W-1:0]     i_func;
    logic [BONE_W-1:0]     i_bone_index;
    logic                  o_valid;
    logic [STATUS_W-1:0]   o_status;
    logic [NEW_W-1:0]      o_new_bones;
    logic [TOTAL_W-1:0]    o_total_referenced;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    admission_check sb;
    bit             gaps_on;
    int             random_sent;
    int             stall_cycles;
    int             window_base;
    int             window_span;

    bone_reference_admission_unit u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_func             (i_func),
        .i_bone_index       (i_bone_index),
        .o_valid            (o_valid),
        .o_status           (o_status),
        .o_new_bones        (o_new_bones),
        .o_total_referenced (o_total_referenced),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_verdict('{o_status, o_new_bones, o_total_referenced});
    end

    // watchdog on cycles without any transfer
    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_valid || (psel && penable))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("bone_reference_admission_unit test failed");
        $finish;
    end

    // one request, with an occasional idle cycle ahead of it
    task automatic send_req(input logic [FUNC_W-1:0] f, input logic [BONE_W-1:0] bone);
        while (gaps_on && $urandom_range(99) < 6) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_func <= f;
        i_bone_index <= bone;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_request(f, bone);
        if (f != FUNC_NOP)
            random_sent++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.verdicts_due.size() != 0) @(posedge i_clk);
    endtask

    // register write only once the block has gone quiet
    task automatic write_limit(input logic [TOTAL_W-1:0] v);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= LIMIT_ADDR;
        pwdata <= {{(APB_DATA_W-TOTAL_W){1'b0}}, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        sb.set_limit(v);
        // read back through the same port
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== {{(APB_DATA_W-TOTAL_W){1'b0}}, v})
            sb.note_mismatch("limit readback", v, prdata);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [BONE_W-1:0] pick_bone();
        if ($urandom_range(99) < 20)
            return BONE_W'($urandom_range(BONES_DEF - 1));
        return BONE_W'(window_base + $urandom_range(window_span));
    endfunction

    task automatic send_triangle(input int n);
        for (int k = 0; k < n; k++)
            send_req(FUNC_SLOT, pick_bone());
        send_req(FUNC_END, '0);
    endtask

    // mostly full triangles, some clears, noise and cut-off triangles
    task automatic run_phase(input int budget);
        int stop_at;
        int r;
        int n;
        stop_at = random_sent + budget;
        window_span = $urandom_range(4, 40);
        while (random_sent < stop_at) begin
            gaps_on = !(random_sent >= 350 && random_sent < 600);
            r = $urandom_range(99);
            if (r < 82) begin
                n = $urandom_range(99);
                if (n < 60) n = TRI_VERTS * WPV_DEF;
                else if (n < 90) n = $urandom_range(1, TRI_VERTS * WPV_DEF - 1);
                else if (n < 95) n = 0;
                else n = $urandom_range(TRI_VERTS * WPV_DEF + 1, TRI_VERTS * WPV_DEF + 3);
                send_triangle(n);
            end else if (r < 90) begin
                send_req(FUNC_CLEAR, BONE_W'($urandom));
                window_base = $urandom_range(BONES_DEF - 1);
            end else if (r < 94) begin
                send_req(FUNC_NOP, BONE_W'($urandom));
            end else begin
                n = $urandom_range(1, 5);
                for (int k = 0; k < n; k++)
                    send_req(FUNC_SLOT, pick_bone());
                if ($urandom_range(1))
                    send_req(FUNC_CLEAR, BONE_W'($urandom));
            end
        end
    endtask

    initial begin
        logic [TOTAL_W-1:0] limits[6];
        sb = new();
        gaps_on = 1'b1;
        random_sent = 0;
        window_base = 0;
        window_span = 8;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_func <= FUNC_SLOT;
        i_bone_index <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset limit of 64
        send_req(FUNC_END, '0);
        send_req(FUNC_SLOT, 7'd0);
        send_req(FUNC_SLOT, 7'd127);
        send_req(FUNC_SLOT, 7'd127);
        send_req(FUNC_END, '0);
        send_req(FUNC_SLOT, 7'd0);
        send_req(FUNC_END, '0);
        // one slot past the triangle capacity
        for (int k = 0; k <= TRI_VERTS * WPV_DEF; k++)
            send_req(FUNC_SLOT, BONE_W'(10 + k));
        send_req(FUNC_END, '0);
        send_req(FUNC_NOP, 7'd127);
        send_req(FUNC_CLEAR, 7'd85);
        send_req(FUNC_END, '0);

        // directed: limit of one, duplicate pending bone right at the limit
        write_limit(8'd1);
        send_req(FUNC_SLOT, 7'd5);
        send_req(FUNC_SLOT, 7'd5);
        send_req(FUNC_END, '0);
        send_req(FUNC_SLOT, 7'd6);
        send_req(FUNC_SLOT, 7'd5);
        send_req(FUNC_END, '0);
        send_req(FUNC_SLOT, 7'd5);
        send_req(FUNC_END, '0);
        send_req(FUNC_SLOT, 7'd9);
        send_req(FUNC_CLEAR, 7'd42);
        send_req(FUNC_END, '0);

        // random phases across limit settings
        random_sent = 0;
        limits = '{8'd0, 8'd128, 8'd3, TOTAL_W'($urandom_range(4, 126)), 8'd127, 8'd64};
        foreach (limits[p]) begin
            write_limit(limits[p]);
            send_req(FUNC_CLEAR, BONE_W'($urandom));
            window_base = $urandom_range(BONES_DEF - 1);
            run_phase(RANDOM_ITEMS / 6 / 2);
            // in the third phase the sender holds off until every verdict is back
            if (p == 2)
                wait_drained();
            run_phase(RANDOM_ITEMS / 6 - RANDOM_ITEMS / 6 / 2);
        end

        wait_drained();
        repeat (BONES_DEF + 16) @(posedge i_clk);
        if (sb.faults == 0 && sb.verdicts_due.size() == 0)
            $display("bone_reference_admission_unit test passed");
        else
            $display("bone_reference_admission_unit test failed");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/bra_pkg.sv
hw/rtl/bra_ram.sv
hw/rtl/bone_reference_admission_unit.sv
test/testbench.sv
